### hdl/hierarchical_timer_wheel_macros.svh
// Assertion macros for the timer wheel checker
`ifndef HIERARCHICAL_TIMER_WHEEL_MACROS_SVH
`define HIERARCHICAL_TIMER_WHEEL_MACROS_SVH
// Implication checked every clock, quiet during reset
`define HTW_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication, quiet during reset
`define HTW_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

### hdl/htw_pkg.sv
// Package: sizes, opcodes and shared types of the timer wheel
`timescale 1ns / 1ps
package htw_pkg;
  localparam int PoolSize = 64;
  localparam int BitsPerLevel = 8;
  localparam int Levels = 4;
  localparam int IdW = 6;
  localparam int Slots = 1 << BitsPerLevel;
  localparam int SlotW = BitsPerLevel + ((Levels > 1) ? $clog2(Levels) : 1);
  localparam int LvlW = (Levels > 1) ? $clog2(Levels) : 1;
  localparam logic [1:0] OP_TICK = 2'd0;
  localparam logic [1:0] OP_INSERT = 2'd1;
  localparam logic [1:0] OP_REMOVE = 2'd2;
  // Link: valid bit and id
  typedef struct packed {
    logic vld;
    logic [IdW-1:0] id;
  } link_t;
  typedef struct packed {
    link_t nxt;
    link_t prv;
    logic [SlotW-1:0] slot;
  } entry_t;
  typedef logic [SlotW-1:0] slot_t;
endpackage

### hdl/htw_slot_ram.sv
// Slot head memory: link per slot, registered read
`timescale 1ns / 1ps
module htw_slot_ram (
  input  logic clk,
  input  logic [htw_pkg::SlotW-1:0] raddr,
  output htw_pkg::link_t rdata,
  input  logic we,
  input  logic [htw_pkg::SlotW-1:0] waddr,
  input  htw_pkg::link_t wdata
);
  import htw_pkg::*;
  localparam int Depth = Levels * Slots;
  link_t mem [Depth];

  // Hold head links in memory, read registered
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

### hdl/htw_entry_ram.sv
// Timer entry memory: expiry, links and home slot, registered read
`timescale 1ns / 1ps
module htw_entry_ram (
  input  logic clk,
  input  logic [htw_pkg::IdW-1:0] raddr,
  output htw_pkg::entry_t rdata,
  output logic [31:0] rexp,
  input  logic we,
  input  logic [htw_pkg::IdW-1:0] waddr,
  input  htw_pkg::entry_t wdata,
  input  logic exp_we,
  input  logic [31:0] wexp
);
  import htw_pkg::*;
  entry_t mem [PoolSize];
  logic [31:0] emem [PoolSize];

  // Write links and expiry, read both registered
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (exp_we) emem[waddr] <= wexp;
    rdata <= mem[raddr];
    rexp <= emem[raddr];
  end
endmodule

### hdl/hierarchical_timer_wheel.sv
// Top level: hierarchical timer wheel sequencer over slot and entry memories
//
// channel | signals                                  | direction
// command | start, busy (out), opcode, timer_id, expire_time | in
// expiry  | expired_strobe, expired_id, last_expired    | out
//
// A fresh insert reads its home slot head and links the timer in front, also updating the
// old head when the slot already holds a list; replacing an active timer unlinks it first.
// Removing an active timer unlinks it; any other remove or an unused opcode does nothing.
// A tick advances the clock, moves timers of cascaded wheels lower, then fires the due slot.
// After the synchronous reset a clearing pass over all 1024 slot heads empties the slot memory,
// with busy held high. Results cannot be stalled: one result beat per strobe cycle.
`timescale 1ns / 1ps
module hierarchical_timer_wheel (
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  logic [1:0] opcode,
  input  logic [5:0] timer_id,
  input  logic [31:0] expire_time,
  output logic expired_strobe,
  output logic [5:0] expired_id,
  output logic last_expired
);
  import htw_pkg::*;

  localparam logic [4:0] S_IDLE = 5'd0, S_UN_RD = 5'd1, S_UN_P = 5'd2, S_UN_PW = 5'd3,
    S_UN_N = 5'd4, S_UN_NW = 5'd5, S_IN_START = 5'd6, S_IN_HD = 5'd7, S_IN_HW = 5'd8,
    S_IN_NX = 5'd9, S_IN_NW = 5'd10, S_TK_LVL = 5'd11, S_CS_RD = 5'd12, S_CS_CLR = 5'd13,
    S_CS_ENT = 5'd14, S_CS_ENTW = 5'd15, S_FR_RD = 5'd16, S_FR_CLR = 5'd17,
    S_FR_ENT = 5'd18, S_FR_ENTW = 5'd19, S_DONE = 5'd20, S_CLR = 5'd21;

  logic [4:0] state;
  logic [31:0] clock_cnt;
  logic [PoolSize-1:0] active;
  logic insert_op, cascading;
  logic [IdW-1:0] cur_id;
  logic [31:0] cur_exp;
  logic [LvlW-1:0] lvl;
  entry_t ent;
  link_t walk, head;
  slot_t home;
  slot_t clr_addr;
  logic [IdW:0] guard;

  // memory ports
  slot_t s_raddr, s_waddr;
  link_t s_rdata, s_wdata;
  logic s_we;
  logic [IdW-1:0] e_raddr, e_waddr;
  entry_t e_rdata, e_wdata;
  logic [31:0] e_rexp, e_wexp;
  logic e_we, e_exp_we;

  htw_slot_ram u_slot (.clk(clk), .raddr(s_raddr), .rdata(s_rdata), .we(s_we),
    .waddr(s_waddr), .wdata(s_wdata));
  htw_entry_ram u_ent (.clk(clk), .raddr(e_raddr), .rdata(e_rdata), .rexp(e_rexp),
    .we(e_we), .waddr(e_waddr), .wdata(e_wdata), .exp_we(e_exp_we), .wexp(e_wexp));

  // Placement: level and slot for expiry against ref, starting at a level
  function automatic slot_t place(input logic [31:0] e, input logic [31:0] r,
                                  input logic [LvlW-1:0] from);
    logic [31:0] d;
    logic [LvlW-1:0] l;
    logic found;
    d = e ^ r;
    l = '0;
    found = 1'b0;
    for (int k = Levels - 1; k > 0; k--) begin
      if (!found && (k <= int'(from)) &&
          (((d >> (k * BitsPerLevel)) & 32'(Slots - 1)) != 32'd0)) begin
        l = LvlW'(k);
        found = 1'b1;
      end
    end
    place = {l, BitsPerLevel'(e >> (int'(l) * BitsPerLevel))};
  endfunction

  // Digit of the clock at a level as a slot address
  function automatic slot_t digit_slot(input logic [31:0] v, input logic [LvlW-1:0] l);
    digit_slot = {l, BitsPerLevel'(v >> (int'(l) * BitsPerLevel))};
  endfunction

  // Home slot of a new timer against the next tick; late timers go to wheel 0
  function automatic slot_t home_of(input logic [31:0] e, input logic [31:0] n);
    if ((e - n) > 32'h8000_0000) home_of = digit_slot(n, '0);
    else home_of = place(e, n, LvlW'(Levels - 1));
  endfunction

  // Highest level to cascade for a given pre-tick clock
  function automatic logic [LvlW-1:0] roll_level(input logic [31:0] c);
    logic [LvlW-1:0] l;
    logic stop;
    l = '0;
    stop = 1'b0;
    for (int k = 0; k < Levels; k++) begin
      if (!stop && ((c >> (k * BitsPerLevel)) & 32'(Slots - 1)) == 32'(Slots - 1)) begin
        if (k + 1 < Levels) l = LvlW'(k + 1);
        else l = LvlW'(Levels - 1);
      end else stop = 1'b1;
    end
    roll_level = l;
  endfunction

  logic [31:0] next_clk;
  assign next_clk = clock_cnt + 32'd1;
  assign busy = (state != S_IDLE);

  // Memory address and write control
  always_comb begin
    s_raddr = '0; s_we = 1'b0; s_waddr = home; s_wdata = '0;
    e_raddr = cur_id; e_we = 1'b0; e_waddr = cur_id; e_wdata = ent;
    e_exp_we = 1'b0; e_wexp = cur_exp;
    unique case (state) inside
      S_CLR: begin
        s_we = 1'b1; s_waddr = clr_addr; s_wdata = '0;
      end
      S_UN_P: begin
        if (e_rdata.prv.vld) begin
          e_raddr = e_rdata.prv.id;
        end else begin
          s_we = 1'b1; s_waddr = e_rdata.slot; s_wdata = e_rdata.nxt;
        end
      end
      S_UN_PW: begin
        e_we = ent.prv.vld; e_waddr = ent.prv.id;
        e_wdata = '{nxt: ent.nxt, prv: e_rdata.prv, slot: e_rdata.slot};
      end
      S_UN_N: e_raddr = ent.nxt.id;
      S_UN_NW: begin
        e_we = ent.nxt.vld; e_waddr = ent.nxt.id;
        e_wdata = '{nxt: e_rdata.nxt, prv: ent.prv, slot: e_rdata.slot};
      end
      S_IN_START, S_IN_HD: s_raddr = home;
      S_IN_HW: begin
        s_we = 1'b1; s_waddr = home; s_wdata = '{vld: 1'b1, id: cur_id};
        e_we = 1'b1; e_waddr = cur_id;
        e_wdata = '{nxt: s_rdata, prv: '0, slot: home};
        e_exp_we = insert_op;
      end
      S_IN_NX: e_raddr = head.id;
      S_IN_NW: begin
        e_we = 1'b1; e_waddr = head.id;
        e_wdata = '{nxt: e_rdata.nxt, prv: '{vld: 1'b1, id: cur_id}, slot: e_rdata.slot};
      end
      S_CS_RD, S_FR_RD: s_raddr = home;
      S_CS_CLR, S_FR_CLR: begin
        s_we = 1'b1; s_waddr = home; s_wdata = '0;
      end
      S_CS_ENT, S_FR_ENT: e_raddr = walk.id;
      S_FR_ENTW: begin
        e_we = 1'b1; e_waddr = walk.id; e_wdata = '{nxt: '0, prv: '0, slot: e_rdata.slot};
      end
      default: ;
    endcase
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLR;
      clr_addr <= '0;
      clock_cnt <= '0;
      active <= '0;
      expired_strobe <= 1'b0;
    end else begin
      expired_strobe <= 1'b0;
      unique case (state)
        S_CLR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == SlotW'(Levels * Slots - 1)) state <= S_IDLE;
        end
        S_IDLE: if (start) begin
          cur_id <= timer_id;
          cur_exp <= expire_time;
          insert_op <= (opcode == OP_INSERT);
          cascading <= 1'b0;
          if (opcode == OP_TICK) begin
            state <= S_TK_LVL;
          end else if ((opcode == OP_INSERT || opcode == OP_REMOVE) &&
                       (32'(timer_id) < 32'(PoolSize))) begin
            if (active[timer_id]) state <= S_UN_RD;
            else if (opcode == OP_INSERT) state <= S_IN_START;
          end
        end
        S_UN_RD: state <= S_UN_P;
        S_UN_P: begin
          ent <= e_rdata;
          state <= S_UN_PW;
        end
        S_UN_PW: begin
          // e_rdata is stale for head case; write skipped there
          state <= S_UN_N;
        end
        S_UN_N: state <= S_UN_NW;
        S_UN_NW: begin
          active[cur_id] <= 1'b0;
          state <= insert_op ? S_IN_START : S_IDLE;
        end
        S_IN_START: begin
          active[cur_id] <= 1'b1;
          state <= S_IN_HD;
        end
        S_IN_HD: state <= S_IN_HW;
        S_IN_HW: begin
          head <= s_rdata;
          state <= s_rdata.vld ? S_IN_NX : (cascading ? S_CS_ENT : S_IDLE);
          if (!s_rdata.vld && cascading) walk <= ent.nxt;
        end
        S_IN_NX: state <= S_IN_NW;
        S_IN_NW: begin
          if (cascading) begin
            walk <= ent.nxt;
            state <= S_CS_ENT;
          end else state <= S_IDLE;
        end
        S_TK_LVL: begin
          clock_cnt <= next_clk;
          lvl <= roll_level(clock_cnt);
          if (roll_level(clock_cnt) != '0) begin
            home <= digit_slot(next_clk, roll_level(clock_cnt));
            state <= S_CS_RD;
          end else begin
            home <= digit_slot(next_clk, '0);
            state <= S_FR_RD;
          end
        end
        S_CS_RD: state <= S_CS_CLR;
        S_CS_CLR: begin
          walk <= s_rdata;
          guard <= '0;
          cascading <= 1'b1;
          state <= S_CS_ENT;
        end
        S_CS_ENT: begin
          if (walk.vld && 32'(guard) < 32'(PoolSize)) state <= S_CS_ENTW;
          else if (lvl > LvlW'(1)) begin
            lvl <= lvl - LvlW'(1);
            home <= digit_slot(clock_cnt, lvl - LvlW'(1));
            state <= S_CS_RD;
          end else begin
            cascading <= 1'b0;
            home <= digit_slot(clock_cnt, '0);
            state <= S_FR_RD;
          end
        end
        S_CS_ENTW: begin
          // relink entry to a lower level: fresh head, so no unlink needed
          ent <= e_rdata;
          cur_id <= walk.id;
          cur_exp <= e_rexp;
          insert_op <= 1'b0;
          guard <= guard + 1'b1;
          home <= place(e_rexp, clock_cnt, lvl - LvlW'(1));
          state <= S_IN_START;
        end
        S_FR_RD: state <= S_FR_CLR;
        S_FR_CLR: begin
          walk <= s_rdata;
          guard <= '0;
          state <= S_FR_ENT;
        end
        S_FR_ENT: begin
          if (walk.vld && 32'(guard) < 32'(PoolSize)) state <= S_FR_ENTW;
          else state <= S_IDLE;
        end
        S_FR_ENTW: begin
          active[walk.id] <= 1'b0;
          expired_strobe <= 1'b1;
          expired_id <= walk.id;
          last_expired <= !(e_rdata.nxt.vld && 32'(guard) + 1 < 32'(PoolSize));
          walk <= e_rdata.nxt;
          guard <= guard + 1'b1;
          state <= S_FR_ENT;
        end
        default: state <= S_IDLE;
      endcase
      // placement of an insert against the next tick
      if (state == S_IDLE && start && opcode == OP_INSERT && !active[timer_id]) begin
        home <= home_of(expire_time, next_clk);
      end else if (state == S_UN_NW) begin
        home <= home_of(cur_exp, next_clk);
      end
    end
  end
endmodule

### hdl/htw_checker.sv
// Port checker for the timer wheel, bound to the top level
`timescale 1ns / 1ps
`include "hierarchical_timer_wheel_macros.svh"
module htw_checker (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic [1:0] opcode,
  input logic expired_strobe,
  input logic last_expired
);
  import htw_pkg::*;
  `HTW_ASSERT_NXT(a_start_busy, start && !busy && (opcode == OP_TICK), busy, "tick not taken")
  `HTW_ASSERT_IMP(a_strobe_busy, expired_strobe, busy || last_expired, "result outside tick")
  `HTW_ASSERT_NXT(a_last_ends, expired_strobe && last_expired, !expired_strobe, "beat after last")
endmodule

bind hierarchical_timer_wheel htw_checker u_htw_checker (.clk(clk), .rst(rst), .start(start),
  .busy(busy), .opcode(opcode), .expired_strobe(expired_strobe),
  .last_expired(last_expired));
